[sv/planar_rotation_by_degrees_core_assert.svh]
// Assertion macros for the planar rotation core.
`ifndef PLANAR_ROTATION_BY_DEGREES_CORE_ASSERT_SVH
`define PLANAR_ROTATION_BY_DEGREES_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/prbd_pkg.sv]
// Shared types, constants and tables for the planar rotation core.
package prbd_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int ITERATIONS  = 16;
	localparam int ANGLE_WIDTH = 16;
	localparam int GUARD       = 8;
	// scaled coordinate plus headroom for the CORDIC gain
	localparam int DP_WIDTH    = COORD_WIDTH + GUARD + 3;
	localparam int Z_WIDTH     = 34;
	localparam int IDX_WIDTH   = 5;
	localparam int MAG_WIDTH   = (DP_WIDTH > 32) ? DP_WIDTH : 33;
	localparam int HI_WIDTH    = MAG_WIDTH - 32;

	// angle reduction: 23040 units per turn = 512 * 45
	localparam int TURN_UNITS  = 23040;
	localparam int U_WIDTH     = 15;
	localparam int QD_WIDTH    = 9;
	localparam int RD_WIDTH    = 6;
	localparam longint unsigned FRAC_DIV = 45;
	localparam int RECIP_45    = 1456;   // floor(2^16 / 45)
	localparam int BAM_SHIFT   = 23;     // 2^32 / 512
	localparam int BAM_BIAS    = 22;     // floor(11520 / 512)

	localparam logic [31:0] INV_GAIN = 32'd2608131497;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [DP_WIDTH-1:0] x;
		logic signed [DP_WIDTH-1:0] y;
		logic signed [Z_WIDTH-1:0]  z;
	} rot_t;

	typedef logic [31:0] frac_tab_t [64];

	// fractional binary angle for a remainder r of u / 45
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t t;
		for (int r = 0; r < 64; r++) begin
			t[r] = 32'(((64'(r) << BAM_SHIFT) + 64'(BAM_BIAS)) / FRAC_DIV);
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

	// round(atan(2^-i) * 2^32 / (2*pi))
	function automatic logic [31:0] atan_val(input logic [IDX_WIDTH-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			5'd31: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[sv/prbd_in_if.sv]
// Input channel: coordinate pair and angle with valid/ready.
interface prbd_in_if import prbd_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_in;
	logic signed [COORD_WIDTH-1:0] second_in;
	logic signed [ANGLE_WIDTH-1:0] angle_deg;

	modport source (output valid, first_in, second_in, angle_deg, input ready);
	modport sink   (input valid, first_in, second_in, angle_deg, output ready);
endinterface

[sv/prbd_out_if.sv]
// Output channel: rotated pair and saturation flag with valid/ready.
interface prbd_out_if import prbd_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_out;
	logic signed [COORD_WIDTH-1:0] second_out;
	logic                          saturated;

	modport source (output valid, first_out, second_out, saturated, input ready);
	modport sink   (input valid, first_out, second_out, saturated, output ready);
endinterface

[sv/prbd_cell.sv]
// One CORDIC micro-rotation cell with its own pipeline register.
module prbd_cell import prbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [IDX_WIDTH-1:0] idx,
	input  logic                 in_valid,
	input  rot_t                 in_data,
	output logic                 out_valid,
	output rot_t                 out_data
);

	logic signed [DP_WIDTH-1:0] dx;
	logic signed [DP_WIDTH-1:0] dy;
	logic signed [Z_WIDTH-1:0]  at;
	rot_t                       nxt;

	always_comb begin
		dx = in_data.y >>> idx;
		dy = in_data.x >>> idx;
		at = signed'(Z_WIDTH'(atan_val(idx)));
		if (!in_data.z[Z_WIDTH-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - at;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

[sv/prbd_gain.sv]
// Gain correction by 1/K, guard-bit rounding and clipping for one coordinate.
module prbd_gain import prbd_pkg::*; (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [DP_WIDTH-1:0]    value,
	output logic signed [COORD_WIDTH-1:0] result,
	output logic                          sat
);

	localparam int P_WIDTH = HI_WIDTH + 32;
	localparam int R_WIDTH = HI_WIDTH + 33;
	localparam int S_WIDTH = R_WIDTH + 1;
	localparam int T_WIDTH = S_WIDTH + 1;

	logic signed [MAG_WIDTH:0] v_ext;
	logic signed [MAG_WIDTH:0] v_abs;
	logic                      neg_s1;
	logic [MAG_WIDTH-1:0]      mag_s1;
	logic                      neg_s2;
	logic [P_WIDTH-1:0]        phi_s2;
	logic [63:0]               plo_s2;
	logic [64:0]               lo_rnd;
	logic [R_WIDTH-1:0]        r_mag;
	logic signed [S_WIDTH-1:0] r_sgn;
	logic signed [S_WIDTH-1:0] sv_s3;
	logic signed [T_WIDTH-1:0] t_rnd;
	logic signed [T_WIDTH-1:0] t_sh;
	logic                      fits;

	always_comb begin
		v_ext  = (MAG_WIDTH+1)'(value);
		v_abs  = v_ext[MAG_WIDTH] ? -v_ext : v_ext;
		// magnitude times 1/K, low half rounded to nearest
		lo_rnd = {1'b0, plo_s2} + 65'h0_8000_0000;
		r_mag  = R_WIDTH'(phi_s2) + R_WIDTH'(lo_rnd[64:32]);
		r_sgn  = neg_s2 ? -signed'({1'b0, r_mag}) : signed'({1'b0, r_mag});
		t_rnd  = T_WIDTH'(sv_s3) + T_WIDTH'(1 << (GUARD - 1));
		t_sh   = t_rnd >>> GUARD;
		fits   = (&t_sh[T_WIDTH-1:COORD_WIDTH-1]) | ~(|t_sh[T_WIDTH-1:COORD_WIDTH-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= v_ext[MAG_WIDTH];
			mag_s1 <= v_abs[MAG_WIDTH-1:0];
			neg_s2 <= neg_s1;
			phi_s2 <= P_WIDTH'(mag_s1[MAG_WIDTH-1:32]) * P_WIDTH'(INV_GAIN);
			plo_s2 <= 64'(mag_s1[31:0]) * 64'(INV_GAIN);
			sv_s3  <= r_sgn;
			sat    <= ~fits;
			if (fits) begin
				result <= t_sh[COORD_WIDTH-1:0];
			end else begin
				result <= t_sh[T_WIDTH-1] ? COORD_MIN : COORD_MAX;
			end
		end
	end

endmodule

[sv/planar_rotation_by_degrees_core.sv]
// Pipeline from input transaction to result: 4 angle/fold stages, ITERATIONS CORDIC
// cells, then 4 gain/round stages.
// Throughput: one transaction per cycle; every stage is a register, the chain
// of cells advances together and stalls only when the output is held.
// Reset clears the valid bit of every stage; payload registers are not reset.
`include "planar_rotation_by_degrees_core_assert.svh"
module planar_rotation_by_degrees_core import prbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	prbd_in_if.sink     rot_in,
	prbd_out_if.source  rot_out
);

	localparam int GAIN_STAGES = 4;

	logic en;

	// angle reduction and quadrant fold
	logic signed [17:0]            a_ext;
	logic signed [17:0]            v_mod;
	logic [U_WIDTH-1:0]            u_red;
	logic                          v_s1, v_s2, v_s3;
	logic [U_WIDTH-1:0]            u_s1, u_s2;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [QD_WIDTH-1:0]           qd0_s2;
	logic [24:0]                   qd_prod;
	logic [15:0]                   rem0;
	logic [QD_WIDTH-1:0]           qd_c;
	logic [RD_WIDTH-1:0]           rd_c;
	logic [QD_WIDTH-1:0]           qd_s3;
	logic [RD_WIDTH-1:0]           rd_s3;
	logic [31:0]                   theta;
	logic                          fold;
	logic signed [COORD_WIDTH:0]   xn, yn;
	rot_t                          fold_d;

	rot_t chain     [ITERATIONS+1];
	logic chain_v   [ITERATIONS+1];
	logic [GAIN_STAGES-1:0] vg_q;
	logic sat_x, sat_y;

	assign en           = !rot_out.valid || rot_out.ready;
	assign rot_in.ready = en;

	always_comb begin
		a_ext = 18'(rot_in.angle_deg);
		v_mod = a_ext + 18'sd46080;
		priority if (v_mod >= 18'sd69120) begin
			u_red = U_WIDTH'(v_mod - 18'sd69120);
		end else if (v_mod >= 18'sd46080) begin
			u_red = U_WIDTH'(v_mod - 18'sd46080);
		end else if (v_mod >= 18'(TURN_UNITS)) begin
			u_red = U_WIDTH'(v_mod - 18'(TURN_UNITS));
		end else begin
			u_red = U_WIDTH'(v_mod);
		end
	end

	assign qd_prod = 25'(u_s1) * 25'(RECIP_45);

	// reciprocal estimate is low by at most one
	always_comb begin
		rem0 = 16'(u_s2) - 16'(qd0_s2) * 16'(FRAC_DIV);
		if (rem0 >= 16'(FRAC_DIV)) begin
			qd_c = qd0_s2 + QD_WIDTH'(1);
			rd_c = RD_WIDTH'(rem0 - 16'(FRAC_DIV));
		end else begin
			qd_c = qd0_s2;
			rd_c = RD_WIDTH'(rem0);
		end
	end

	always_comb begin
		theta = {qd_s3, FRAC_TAB[rd_s3][BAM_SHIFT-1:0]};
		fold  = theta[31] ^ theta[30];
		xn    = (COORD_WIDTH+1)'(x_s3);
		yn    = (COORD_WIDTH+1)'(y_s3);
		if (fold) begin
			xn       = -xn;
			yn       = -yn;
			theta[31] = ~theta[31];
		end
		fold_d.x = DP_WIDTH'(xn) <<< GUARD;
		fold_d.y = DP_WIDTH'(yn) <<< GUARD;
		fold_d.z = Z_WIDTH'(signed'(theta));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			chain_v[0] <= 1'b0;
		end else if (en) begin
			v_s1       <= rot_in.valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			chain_v[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1     <= u_red;
			x_s1     <= rot_in.first_in;
			y_s1     <= rot_in.second_in;
			u_s2     <= u_s1;
			qd0_s2   <= qd_prod[QD_WIDTH+15:16];
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			qd_s3    <= qd_c;
			rd_s3    <= rd_c;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			chain[0] <= fold_d;
		end
	end

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		prbd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (IDX_WIDTH'(k)),
			.in_valid  (chain_v[k]),
			.in_data   (chain[k]),
			.out_valid (chain_v[k+1]),
			.out_data  (chain[k+1])
		);
	end

	prbd_gain u_gain_x (
		.clk    (clk),
		.en     (en),
		.value  (chain[ITERATIONS].x),
		.result (rot_out.first_out),
		.sat    (sat_x)
	);

	prbd_gain u_gain_y (
		.clk    (clk),
		.en     (en),
		.value  (chain[ITERATIONS].y),
		.result (rot_out.second_out),
		.sat    (sat_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_q <= '0;
		end else if (en) begin
			vg_q <= {vg_q[GAIN_STAGES-2:0], chain_v[ITERATIONS]};
		end
	end

	assign rot_out.valid     = vg_q[GAIN_STAGES-1];
	assign rot_out.saturated = sat_x | sat_y;

	`PRBD_ASSERT_NOW(a_rem_range, v_s3, rd_s3 < RD_WIDTH'(FRAC_DIV), "angle remainder not below 45")
	`PRBD_ASSERT_NOW(a_fold_range, chain_v[0], chain[0].z[Z_WIDTH-1:30] == '0 || chain[0].z[Z_WIDTH-1:30] == '1, "folded angle outside quarter turn")
	`PRBD_ASSERT_NOW(a_sat_clip, rot_out.valid && rot_out.saturated, rot_out.first_out == COORD_MAX || rot_out.first_out == COORD_MIN || rot_out.second_out == COORD_MAX || rot_out.second_out == COORD_MIN, "saturated without a clipped output")
	`PRBD_ASSERT_NEXT(a_hold, rot_out.valid && !rot_out.ready, rot_out.valid && $stable(chain[ITERATIONS]), "pipeline moved while output stalled")

endmodule

[tb/tb_top.sv]
// Testbench for the planar rotation core: stream driver, scoreboard and rotation predictor.
`timescale 1ns / 100ps

module tb_top import prbd_pkg::*;;

	localparam int N_RANDOM    = 430;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] first;
		logic signed [COORD_WIDTH-1:0] second;
		logic signed [ANGLE_WIDTH-1:0] angle;
	} pair_item_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] first;
		logic signed [COORD_WIDTH-1:0] second;
		logic                          sat;
	} rotated_t;

	logic clk;
	logic arst_n;

	prbd_in_if  rot_in_if ();
	prbd_out_if rot_out_if ();

	planar_rotation_by_degrees_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rot_in  (rot_in_if),
		.rot_out (rot_out_if)
	);

	pair_item_t pending_pairs[$];
	rotated_t   expected_rot[$];
	pair_item_t next_pair;
	rotated_t   want;
	int         n_accepted;
	int         n_results;
	int         n_clipped;
	int         n_errors;
	int         cycles;

	// binary-angle arctangent of 2^-i, one turn = 2^32
	longint unsigned atan_q32 [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	// multiply by 1/K with the magnitude rounded half away from zero
	function automatic longint scale_gain(input longint v);
		longint unsigned mag;
		longint unsigned prod;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		prod = (mag >> 32) * INV_GAIN
			+ (((mag & 64'hFFFF_FFFF) * INV_GAIN + 64'h8000_0000) >> 32);
		return (v < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] round_clip(input longint v,
			inout logic sat);
		longint r;
		r = (v + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
		if (r > longint'(COORD_MAX)) begin
			r = longint'(COORD_MAX);
			sat = 1'b1;
		end
		if (r < longint'(COORD_MIN)) begin
			r = longint'(COORD_MIN);
			sat = 1'b1;
		end
		return r[COORD_WIDTH-1:0];
	endfunction

	function automatic rotated_t rotate_pair(input pair_item_t p);
		rotated_t        res;
		longint          x;
		longint          y;
		longint          z;
		longint          dx;
		longint          dy;
		int              ang;
		int              turn_pos;
		longint unsigned bam_wide;
		logic [31:0]     bam;
		x = longint'(p.first);
		y = longint'(p.second);
		ang = int'(p.angle);
		turn_pos = (ang + 2 * TURN_UNITS) % TURN_UNITS;
		bam_wide = ((longint'(turn_pos) << 32) + TURN_UNITS / 2) / TURN_UNITS;
		bam = bam_wide[31:0];
		// fold the second and third quadrants by a half turn
		if (bam[31:30] == 2'b01 || bam[31:30] == 2'b10) begin
			bam = bam + 32'h8000_0000;
			x = -x;
			y = -y;
		end
		z = longint'($signed(bam));
		x = x <<< GUARD;
		y = y <<< GUARD;
		for (int i = 0; i < ITERATIONS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(atan_q32[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(atan_q32[i]);
			end
		end
		res.sat = 1'b0;
		res.first = round_clip(scale_gain(x), res.sat);
		res.second = round_clip(scale_gain(y), res.sat);
		return res;
	endfunction

	// three traffic phases keyed on accepted transactions
	function automatic int src_idle_pct(input int done);
		if (done < 170) return 8;
		if (done < 320) return 71;
		return 0;
	endfunction

	function automatic int sink_stall_pct(input int done);
		if (done < 170) return 71;
		if (done < 320) return 8;
		return 0;
	endfunction

	function automatic pair_item_t make_pair(input int f, input int s, input int a);
		pair_item_t p;
		p.first = COORD_WIDTH'(f);
		p.second = COORD_WIDTH'(s);
		p.angle = ANGLE_WIDTH'(a);
		return p;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// input driver; the prediction is taken at the accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_in_if.valid <= 1'b0;
			rot_in_if.first_in <= '0;
			rot_in_if.second_in <= '0;
			rot_in_if.angle_deg <= '0;
		end else begin
			if (rot_in_if.valid && rot_in_if.ready) begin
				expected_rot.push_back(rotate_pair(make_pair(int'(rot_in_if.first_in),
					int'(rot_in_if.second_in), int'(rot_in_if.angle_deg))));
				n_accepted++;
			end
			if (!rot_in_if.valid || rot_in_if.ready) begin
				if (pending_pairs.size() != 0
						&& $urandom_range(99) >= src_idle_pct(n_accepted)) begin
					next_pair = pending_pairs.pop_front();
					rot_in_if.valid <= 1'b1;
					rot_in_if.first_in <= next_pair.first;
					rot_in_if.second_in <= next_pair.second;
					rot_in_if.angle_deg <= next_pair.angle;
				end else begin
					rot_in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_out_if.ready <= 1'b0;
		end else begin
			if (rot_out_if.valid && rot_out_if.ready) begin
				n_results++;
				if (rot_out_if.saturated) n_clipped++;
				if (expected_rot.size() == 0) begin
					$error("result transaction with nothing expected: %0d %0d %0b",
						rot_out_if.first_out, rot_out_if.second_out,
						rot_out_if.saturated);
					n_errors++;
				end else begin
					want = expected_rot.pop_front();
					if (rot_out_if.first_out !== want.first) begin
						$error("first_out: expected %0d, got %0d", want.first,
							rot_out_if.first_out);
						n_errors++;
					end
					if (rot_out_if.second_out !== want.second) begin
						$error("second_out: expected %0d, got %0d", want.second,
							rot_out_if.second_out);
						n_errors++;
					end
					if (rot_out_if.saturated !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat,
							rot_out_if.saturated);
						n_errors++;
					end
				end
			end
			rot_out_if.ready <= ($urandom_range(99) >= sink_stall_pct(n_accepted));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_rot.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int f;
		int s;
		int a;
		int kind;
		arst_n = 1'b0;
		rot_in_if.valid = 1'b0;
		rot_in_if.first_in = '0;
		rot_in_if.second_in = '0;
		rot_in_if.angle_deg = '0;
		rot_out_if.ready = 1'b0;
		n_accepted = 0;
		n_results = 0;
		n_clipped = 0;
		n_errors = 0;
		cycles = 0;

		// directed: quadrant edges, wrap-around, coordinate extremes, clipping
		pending_pairs.push_back(make_pair(32'h0001_0000, 0, 0));
		pending_pairs.push_back(make_pair(32'h0001_0000, 0, 5760));
		pending_pairs.push_back(make_pair(32'h0001_0000, 0, 11520));
		pending_pairs.push_back(make_pair(32'h0001_0000, 0, 17280));
		pending_pairs.push_back(make_pair(0, 32'h0001_0000, -5760));
		pending_pairs.push_back(make_pair(32'h0003_0000, 32'h0004_0000, 5759));
		pending_pairs.push_back(make_pair(32'h0003_0000, 32'h0004_0000, 17281));
		pending_pairs.push_back(make_pair(32'h0002_0000, -32'h0005_0000, 23039));
		pending_pairs.push_back(make_pair(32'h0002_0000, -32'h0005_0000, -23040));
		pending_pairs.push_back(make_pair(32'h0001_8000, 32'h0000_4000, 32767));
		pending_pairs.push_back(make_pair(32'h0001_8000, 32'h0000_4000, -32768));
		pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2880));
		pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 2880));
		pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h8000_0000, -2880));
		pending_pairs.push_back(make_pair(32'h8000_0000, 0, 0));
		pending_pairs.push_back(make_pair(32'h8000_0000, 0, 11520));
		pending_pairs.push_back(make_pair(0, 32'h8000_0000, 5760));
		pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		pending_pairs.push_back(make_pair(0, 0, 1234));
		pending_pairs.push_back(make_pair(1, -1, 1));
		pending_pairs.push_back(make_pair(-1, 1, -1));
		pending_pairs.push_back(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 8640));

		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				f = $urandom;
				s = $urandom;
				a = $urandom_range(16'hFFFF);
				a = int'($signed(16'(a)));
			end else if (kind < 70) begin
				// modest coordinates, angle inside one turn either way
				f = int'($urandom_range(33554432)) - 16777216;
				s = int'($urandom_range(33554432)) - 16777216;
				a = int'($urandom_range(46079)) - 23040;
			end else if (kind < 85) begin
				f = $urandom_range(1) ? 32'h7FFF_FFFF - int'($urandom_range(255))
					: 32'h8000_0000 + int'($urandom_range(255));
				s = $urandom_range(1) ? 32'h7FFF_FFFF - int'($urandom_range(255))
					: 32'h8000_0000 + int'($urandom_range(255));
				a = int'($urandom_range(65535)) - 32768;
			end else begin
				// multiples of 45 degrees, off by at most one unit
				f = $urandom;
				s = $urandom;
				a = 2880 * int'($urandom_range(15)) - 23040 + int'($urandom_range(2)) - 1;
			end
			pending_pairs.push_back(make_pair(f, s, a));
		end

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		while (pending_pairs.size() != 0 || rot_in_if.valid || expected_rot.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (expected_rot.size() != 0) begin
			$error("%0d expected results never arrived", expected_rot.size());
			n_errors++;
		end
		$display("Rotated %0d coordinate pairs (%0d results, %0d clipped) over three",
			n_accepted, n_results, n_clipped);
		$display("traffic phases: light/heavy idling, heavy/light idling, none.");
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
